// File: rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg: shared definitions for the spike delay queue
// Field widths, command and status codes, and the command/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 16;
  localparam int VALUE_W  = 16;
  localparam int DELAY_W  = 8;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 7;

  // Slot word layouts: {x, y, z} and {value, delay}
  localparam int CRD_W = 3 * COORD_W;
  localparam int VD_W  = VALUE_W + DELAY_W;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK    = 3'd4;

  typedef struct packed {
    logic                push_write;
    logic                scan_clear;
    logic                scan_step;
    logic                tick_write;
    logic                shift_write;
    logic                load_found;
    logic                count_dec;
    logic                emit;
    logic [STATUS_W-1:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_end;
    logic rd_pend;
    logic rd_due;
  } dp_sts_t;

endpackage

// File: rtl/spike_delay_queue.sv
// ----------------------------------------------------------------------------
// spike_delay_queue: ordered queue of delayed spike events
// Push, pop-oldest-due and tick commands over QUEUE_DEPTH stored events.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done high, and the receiver
// cannot stall it. Push and the unused command code give their result in the
// cycle after the request and never raise busy. Tick and pop hold busy while
// they sweep the slot memories through their single read and write port, one
// slot per cycle, for the aging pass, the due search and the move that closes
// the gap behind a popped event; on an empty queue either one holds busy for
// one cycle. done rises in the same cycle that busy falls. A new request may
// be issued in the same cycle that done is high.
module spike_delay_queue #(
  parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic        [sdq_pkg::CMD_W-1:0]    command,
  input  logic signed [sdq_pkg::COORD_W-1:0]  target_x,
  input  logic signed [sdq_pkg::COORD_W-1:0]  target_y,
  input  logic signed [sdq_pkg::COORD_W-1:0]  target_z,
  input  logic signed [sdq_pkg::VALUE_W-1:0]  event_value,
  input  logic        [sdq_pkg::DELAY_W-1:0]  delay_ticks,
  output logic                                done,
  output logic        [sdq_pkg::STATUS_W-1:0] status,
  output logic signed [sdq_pkg::COORD_W-1:0]  out_x,
  output logic signed [sdq_pkg::COORD_W-1:0]  out_y,
  output logic signed [sdq_pkg::COORD_W-1:0]  out_z,
  output logic signed [sdq_pkg::VALUE_W-1:0]  out_value,
  output logic        [sdq_pkg::OCC_W-1:0]    occupancy
);
  import sdq_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  sdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (dp_sts),
    .busy    (busy),
    .cmd     (dp_cmd)
  );

  sdq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .target_x    (target_x),
    .target_y    (target_y),
    .target_z    (target_z),
    .event_value (event_value),
    .delay_ticks (delay_ticks),
    .sts         (dp_sts),
    .done        (done),
    .status      (status),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_value   (out_value),
    .occupancy   (occupancy)
  );

  // Push gives its result in the very next cycle
  a_push_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == CMD_PUSH) |=> done &&
      ((status == ST_PUSHED) || (status == ST_DROPPED)))
    else $error("push request did not complete in one cycle");

  // Tick and pop enter a sweep
  a_sweep_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && ((command == CMD_TICK) || (command == CMD_POP)) |=> busy)
    else $error("sweep request did not raise busy");

  // A result is never shown while a sweep is still running
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe during busy");

  // Only a popped event carries fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_POPPED) |->
      (out_x == '0) && (out_y == '0) && (out_z == '0) && (out_value == '0))
    else $error("event fields not cleared on non-pop result");

endmodule

// File: rtl/sdq_datapath.sv
// ----------------------------------------------------------------------------
// sdq_datapath: slot memories, occupancy count and sweep pointer
// Holds the events in two memories with a read and a write port each, sweeps
// them one slot per cycle for tick and pop, and registers the result fields.
// ----------------------------------------------------------------------------
module sdq_datapath #(
  parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sdq_pkg::dp_cmd_t                    cmd,
  input  logic signed [sdq_pkg::COORD_W-1:0]  target_x,
  input  logic signed [sdq_pkg::COORD_W-1:0]  target_y,
  input  logic signed [sdq_pkg::COORD_W-1:0]  target_z,
  input  logic signed [sdq_pkg::VALUE_W-1:0]  event_value,
  input  logic        [sdq_pkg::DELAY_W-1:0]  delay_ticks,
  output sdq_pkg::dp_sts_t                    sts,
  output logic                                done,
  output logic        [sdq_pkg::STATUS_W-1:0] status,
  output logic signed [sdq_pkg::COORD_W-1:0]  out_x,
  output logic signed [sdq_pkg::COORD_W-1:0]  out_y,
  output logic signed [sdq_pkg::COORD_W-1:0]  out_z,
  output logic signed [sdq_pkg::VALUE_W-1:0]  out_value,
  output logic        [sdq_pkg::OCC_W-1:0]    occupancy
);
  import sdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CRD_W-1:0] coord_mem [QUEUE_DEPTH];
  logic [VD_W-1:0]  vd_mem    [QUEUE_DEPTH];

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    ptr;
  logic             rd_pend;
  logic [AW-1:0]    rd_addr;
  logic [CRD_W-1:0] coord_rd;
  logic [VD_W-1:0]  vd_rd;

  logic             rd_en;
  logic             due;
  logic [DELAY_W-1:0] delay_dec;
  logic             c_we;
  logic             v_we;
  logic [AW-1:0]    wa;
  logic [CRD_W-1:0] c_wd;
  logic [VD_W-1:0]  v_wd;

  assign due       = (vd_rd[DELAY_W-1:0] == '0);
  assign delay_dec = due ? '0 : vd_rd[DELAY_W-1:0] - DELAY_W'(1);

  assign sts.full     = (count == CW'(QUEUE_DEPTH));
  assign sts.scan_end = (ptr == count);
  assign sts.rd_pend  = rd_pend;
  assign sts.rd_due   = due;

  assign rd_en = cmd.scan_step && !sts.scan_end;

  always_comb begin
    count_next = count;
    if (cmd.push_write) begin
      count_next = count + CW'(1);
    end else if (cmd.count_dec) begin
      count_next = count - CW'(1);
    end
  end

  // Single write port: append, age in place, or move a slot down by one
  always_comb begin
    c_we = 1'b0;
    v_we = 1'b0;
    wa   = '0;
    c_wd = coord_rd;
    v_wd = vd_rd;
    if (cmd.push_write) begin
      c_we = 1'b1;
      v_we = 1'b1;
      wa   = count[AW-1:0];
      c_wd = {target_x, target_y, target_z};
      v_wd = {event_value, delay_ticks};
    end else if (cmd.tick_write && rd_pend) begin
      v_we = 1'b1;
      wa   = rd_addr;
      v_wd = {vd_rd[VD_W-1:DELAY_W], delay_dec};
    end else if (cmd.shift_write && rd_pend) begin
      c_we = 1'b1;
      v_we = 1'b1;
      wa   = rd_addr - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      coord_mem[wa] <= c_wd;
    end
    if (v_we) begin
      vd_mem[wa] <= v_wd;
    end
    if (rd_en) begin
      coord_rd <= coord_mem[ptr[AW-1:0]];
      vd_rd    <= vd_mem[ptr[AW-1:0]];
      rd_addr  <= ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ptr     <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.emit;
      if (cmd.scan_clear) begin
        ptr     <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.load_found) begin
        // restart the sweep just past the popped slot and drop the stale read
        ptr     <= CW'(rd_addr) + CW'(1);
        rd_pend <= 1'b0;
      end else begin
        if (rd_en) begin
          ptr <= ptr + CW'(1);
        end
        rd_pend <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_found) begin
      out_x     <= coord_rd[3*COORD_W-1 -: COORD_W];
      out_y     <= coord_rd[2*COORD_W-1 -: COORD_W];
      out_z     <= coord_rd[COORD_W-1:0];
      out_value <= vd_rd[VD_W-1:DELAY_W];
    end
    if (cmd.emit) begin
      status    <= cmd.code;
      occupancy <= OCC_W'(count_next);
      if (cmd.code != ST_POPPED) begin
        out_x     <= '0;
        out_y     <= '0;
        out_z     <= '0;
        out_value <= '0;
      end
    end
  end

endmodule

// File: rtl/sdq_ctrl.sv
// ----------------------------------------------------------------------------
// sdq_ctrl: command sequencer for the spike delay queue
// Decodes each request and steps the datapath through append, aging sweep,
// due-slot search and gap closing.
// ----------------------------------------------------------------------------
module sdq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sdq_pkg::CMD_W-1:0]   command,
  input  sdq_pkg::dp_sts_t            sts,
  output logic                        busy,
  output sdq_pkg::dp_cmd_t            cmd
);
  import sdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TICK  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic sweep_drained;

  assign busy          = (state != S_IDLE);
  assign sweep_drained = sts.scan_end && !sts.rd_pend;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_PUSH: begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.code = ST_DROPPED;
              end else begin
                cmd.push_write = 1'b1;
                cmd.code       = ST_PUSHED;
              end
            end
            CMD_POP: begin
              cmd.scan_clear = 1'b1;
              state_next     = S_SCAN;
            end
            CMD_TICK: begin
              cmd.scan_clear = 1'b1;
              state_next     = S_TICK;
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.code = ST_NONE;
            end
          endcase
        end
      end
      S_TICK: begin
        cmd.scan_step  = 1'b1;
        cmd.tick_write = 1'b1;
        if (sweep_drained) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_TICK;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.rd_pend && sts.rd_due) begin
          cmd.load_found = 1'b1;
          state_next     = S_SHIFT;
        end else if (sweep_drained) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_NONE;
          state_next = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.scan_step   = 1'b1;
        cmd.shift_write = 1'b1;
        if (sweep_drained) begin
          cmd.count_dec = 1'b1;
          cmd.emit      = 1'b1;
          cmd.code      = ST_POPPED;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for spike_delay_queue
// Drives push, pop, tick and unused-code requests through the start/busy
// handshake with random gaps, predicts every result from a local copy of the
// event store, and checks each done strobe field by field against it.
// ----------------------------------------------------------------------------
module tb;
  import sdq_pkg::*;

  localparam int QD         = QUEUE_DEPTH_DEF;
  localparam int N_RANDOM   = 1350;
  localparam int LOG_SIZE   = 8192;
  localparam int CYCLE_CAP  = 1000000;
  localparam int TAIL_WAIT  = 2 * QD + 10;
  localparam int PRINT_CAP  = 30;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic        [CMD_W-1:0]   cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [VALUE_W-1:0] val;
    logic        [DELAY_W-1:0] dly;
    int                        gap;
    bit                        drain;
  } request_t;

  typedef struct {
    logic        [STATUS_W-1:0] status;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic signed [VALUE_W-1:0]  val;
    logic        [OCC_W-1:0]    occ;
  } outcome_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [CMD_W-1:0]      command = '0;
  logic signed [15:0]    target_x = '0;
  logic signed [15:0]    target_y = '0;
  logic signed [15:0]    target_z = '0;
  logic signed [15:0]    event_value = '0;
  logic [DELAY_W-1:0]    delay_ticks = '0;
  logic                  busy;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic signed [15:0]    out_x;
  logic signed [15:0]    out_y;
  logic signed [15:0]    out_z;
  logic signed [15:0]    out_value;
  logic [OCC_W-1:0]      occupancy;

  spike_delay_queue #(.QUEUE_DEPTH(QD)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .target_x    (target_x),
    .target_y    (target_y),
    .target_z    (target_z),
    .event_value (event_value),
    .delay_ticks (delay_ticks),
    .done        (done),
    .status      (status),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_value   (out_value),
    .occupancy   (occupancy)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Local copy of the event store
  logic signed [15:0] ev_x [QD];
  logic signed [15:0] ev_y [QD];
  logic signed [15:0] ev_z [QD];
  logic signed [15:0] ev_val [QD];
  logic [7:0]         ev_dly [QD];
  int                 ev_held = 0;

  request_t pending_requests[$];
  outcome_t predicted_results [LOG_SIZE];
  int       n_acc = 0;
  int       n_res = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       in_burst = 1'b0;

  int n_pushed = 0, n_dropped = 0, n_popped = 0, n_none = 0, n_ticks = 0, peak_occ = 0;

  function automatic outcome_t apply_request(request_t rq);
    outcome_t r;
    int hit;
    r.status = ST_NONE;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    r.val = '0;
    hit = -1;
    case (rq.cmd)
      CMD_PUSH: begin
        if (ev_held >= QD) begin
          r.status = ST_DROPPED;
        end else begin
          ev_x[ev_held] = rq.x;
          ev_y[ev_held] = rq.y;
          ev_z[ev_held] = rq.z;
          ev_val[ev_held] = rq.val;
          ev_dly[ev_held] = rq.dly;
          ev_held++;
          r.status = ST_PUSHED;
        end
      end
      CMD_POP: begin
        for (int i = 0; i < ev_held; i++)
          if (hit < 0 && ev_dly[i] == 0) hit = i;
        if (hit >= 0) begin
          r.status = ST_POPPED;
          r.x = ev_x[hit];
          r.y = ev_y[hit];
          r.z = ev_z[hit];
          r.val = ev_val[hit];
          // close the gap, keep arrival order
          for (int j = hit; j < ev_held - 1; j++) begin
            ev_x[j] = ev_x[j+1];
            ev_y[j] = ev_y[j+1];
            ev_z[j] = ev_z[j+1];
            ev_val[j] = ev_val[j+1];
            ev_dly[j] = ev_dly[j+1];
          end
          ev_held--;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < ev_held; i++)
          if (ev_dly[i] != 0) ev_dly[i]--;
        r.status = ST_TICK;
      end
      default: r.status = ST_NONE;
    endcase
    r.occ = ev_held[OCC_W-1:0];
    return r;
  endfunction

  task automatic add_req(logic [CMD_W-1:0] cmd, logic [15:0] x, logic [15:0] y,
                         logic [15:0] z, logic [15:0] val, logic [7:0] dly, bit drain);
    request_t rq;
    rq.cmd = cmd;
    rq.x = x;
    rq.y = y;
    rq.z = z;
    rq.val = val;
    rq.dly = dly;
    rq.gap = in_burst ? 0 : $urandom_range(0, 16);
    rq.drain = drain;
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP)
      $display("ERROR at %0t ns, result %0d: %s", $time, n_res, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Driver: present queued requests, hold while busy, wait out each request's gap
  request_t cur_req;
  request_t next_req;
  bit       took;
  int       gap_left = 0;
  int       outstanding;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        predicted_results[n_acc % LOG_SIZE] = apply_request(cur_req);
        n_acc <= n_acc + 1;
      end
      if (!start || took) begin
        outstanding = n_acc + took - n_res - (done === 1'b1 ? 1 : 0);
        if (pending_requests.size() == 0) begin
          start <= 1'b0;
        end else begin
          next_req = pending_requests[0];
          if (gap_left < next_req.gap) begin
            gap_left <= gap_left + 1;
            start <= 1'b0;
          end else if (next_req.drain && outstanding != 0) begin
            // hold until every result is back
            start <= 1'b0;
          end else begin
            cur_req = next_req;
            void'(pending_requests.pop_front());
            gap_left <= 0;
            start <= 1'b1;
            command <= next_req.cmd;
            target_x <= next_req.x;
            target_y <= next_req.y;
            target_z <= next_req.z;
            event_value <= next_req.val;
            delay_ticks <= next_req.dly;
          end
        end
      end
    end
  end

  // Monitor: every done strobe is matched against the oldest prediction
  outcome_t want;

  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (done !== 1'b1) begin
        report_mismatch("done is unknown");
      end else begin
        if (n_res >= n_acc) begin
          report_mismatch($sformatf("result with no request outstanding, status %0d", status));
        end else begin
          want = predicted_results[n_res % LOG_SIZE];
          check_field("status", 16'(status), 16'(want.status));
          check_field("out_x", out_x, want.x);
          check_field("out_y", out_y, want.y);
          check_field("out_z", out_z, want.z);
          check_field("out_value", out_value, want.val);
          check_field("occupancy", 16'(occupancy), 16'(want.occ));
          n_res <= n_res + 1;
        end
        case (status)
          ST_PUSHED:  n_pushed++;
          ST_DROPPED: n_dropped++;
          ST_POPPED:  n_popped++;
          ST_NONE:    n_none++;
          ST_TICK:    n_ticks++;
          default:    ;
        endcase
        if (occupancy > peak_occ) peak_occ = occupancy;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d of %0d results seen", cycle_count, n_res, n_acc);
      $display("spike_delay_queue: mismatch");
      $finish;
    end
  end

  initial begin
    int counted;
    int len;
    int pick;
    bit first;
    phase_t mode;
    logic [CMD_W-1:0] cmd;
    logic [7:0] dly;

    counted = 0;
    first = 1'b1;

    // Directed: empty queue, field extremes, zero and saturating delays
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            8'($urandom), 1'b0);
    add_req(CMD_PUSH, 16'h8000, 16'h7fff, 16'h0000, 16'h8000, 8'd0, 1'b0);
    add_req(CMD_PUSH, 16'h7fff, 16'h8000, 16'hffff, 16'h7fff, 8'd255, 1'b0);
    add_req(CMD_PUSH, 16'h0000, 16'hffff, 16'h8000, 16'hffff, 8'd1, 1'b0);
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_PUSH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            8'd0, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_POP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b0);
    add_req(CMD_PUSH, 16'h1234, 16'hedcb, 16'h0001, 16'h1000, 8'd2, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_TICK, '0, '0, '0, '0, '0, 1'b0);
    add_req(CMD_POP, '0, '0, '0, '0, '0, 1'b0);

    // Random phases: fill to overflow, drain with aging, mixed traffic
    while (counted < N_RANDOM) begin
      if (first) begin
        mode = PH_FILL;
        len = 90;
      end else begin
        mode = phase_t'($urandom_range(0, 2));
        len = $urandom_range(20, 120);
      end
      in_burst = ($urandom_range(0, 9) < 3);
      for (int k = 0; k < len && counted < N_RANDOM; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          cmd = CMD_UNUSED;
        end else begin
          pick = $urandom_range(0, 99);
          case (mode)
            PH_FILL:  cmd = (pick < 85) ? CMD_PUSH : (pick < 90) ? CMD_POP : CMD_TICK;
            PH_DRAIN: cmd = (pick < 5) ? CMD_PUSH : (pick < 65) ? CMD_POP : CMD_TICK;
            default:  cmd = (pick < 40) ? CMD_PUSH : (pick < 75) ? CMD_POP : CMD_TICK;
          endcase
          counted++;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50)      dly = 8'($urandom_range(0, 3));
        else if (pick < 75) dly = 8'($urandom_range(4, 20));
        else if (pick < 90) dly = 8'($urandom);
        else                dly = (pick < 95) ? 8'd255 : 8'd0;
        add_req(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), dly,
                first || ($urandom_range(0, 39) == 0));
        first = 1'b0;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start) @(posedge clk);
    while (n_res != n_acc) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("ran %0d requests: %0d pushed, %0d dropped on full, %0d popped, %0d none due",
             n_acc, n_pushed, n_dropped, n_popped, n_none);
    $display("%0d ticks, peak occupancy %0d of %0d, %0d cycles", n_ticks, peak_occ, QD,
             cycle_count);
    if (mismatches == 0 && n_res == n_acc) begin
      $display("spike_delay_queue: match");
    end else begin
      $display("spike_delay_queue: mismatch");
    end
    $finish;
  end

endmodule
